/* rtl/iso_dec_pkg.sv */
package iso_dec_pkg;

	localparam int NAME_BUFFER_BYTES_DEF = 256;

	// Name status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DOTNAME = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam logic [7:0] UTF_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF_CONT  = 8'h80;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       name_done;
		logic [1:0] status;
		logic       run_last;
	} res_t;

endpackage

/* rtl/iso_dec_core.sv */
module iso_dec_core import iso_dec_pkg::*; #(
	parameter int NAME_BUFFER_BYTES = NAME_BUFFER_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             joliet_mode,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output res_t [2:0]       res,
	output logic [1:0]       res_n
);

	localparam int CNT_W = $clog2(NAME_BUFFER_BYTES);
	localparam logic [CNT_W+1:0] NB = (CNT_W+2)'(NAME_BUFFER_BYTES);

	logic             started_q, nj_q, ph_q, stop_q, held_q, inv_q, dots_q;
	logic [7:0]       hi_q;
	logic [CNT_W-1:0] cnt_q;

	logic             started_n, nj_n, ph_n, stop_n, held_n, inv_n, dots_n;
	logic [7:0]       hi_n;
	logic [CNT_W-1:0] cnt_n;

	logic             nj, single_dot, proc, go_on;
	logic [15:0]      cp;
	logic [7:0]       e [3];
	logic [1:0]       k;
	logic [CNT_W+1:0] cnt_w;
	logic [1:0]       st;

	function automatic logic is_bad(input logic [7:0] c);
		return (c < 8'd32) || (c == 8'h2F) || (c == 8'h5C) || (c == 8'h3A);
	endfunction

	assign nj         = started_q ? nj_q : joliet_mode;
	assign single_dot = in_last && !started_q && (in_byte <= 8'd1);
	assign proc       = !single_dot && !stop_q;
	assign cp         = {hi_q, in_byte};

	always_comb begin
		hi_n   = hi_q;
		ph_n   = ph_q;
		stop_n = stop_q;
		held_n = held_q;
		inv_n  = inv_q;
		go_on  = 1'b1;
		k      = 2'd0;
		e[0]   = 8'h00;
		e[1]   = 8'h00;
		e[2]   = 8'h00;
		if (proc) begin
			if (nj) begin
				if (!ph_q) begin
					if (!in_last) begin
						hi_n = in_byte;
						ph_n = 1'b1;
					end
				end else begin
					ph_n = 1'b0;
					if (cp == 16'h0000 || cp == {8'h00, CH_SEMI}) begin
						stop_n = 1'b1;
					end else if (cp > 16'h007F) begin
						// wide unit needs room for three bytes, else dropped
						if (({2'b00, cnt_q} + (CNT_W+2)'(3)) < NB) begin
							if (cp < 16'h0800) begin
								e[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
								e[1] = UTF_CONT | {2'b00, cp[5:0]};
								k    = 2'd2;
							end else begin
								e[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
								e[1] = UTF_CONT | {2'b00, cp[11:6]};
								e[2] = UTF_CONT | {2'b00, cp[5:0]};
								k    = 2'd3;
							end
						end
					end else if (is_bad(in_byte)) begin
						inv_n  = 1'b1;
						stop_n = 1'b1;
						held_n = 1'b0;
					end else begin
						e[0] = in_byte;
						k    = 2'd1;
					end
				end
			end else begin
				if (held_q) begin
					held_n = 1'b0;
					if (in_byte == CH_SEMI) begin
						stop_n = 1'b1;
						go_on  = 1'b0;
					end else begin
						e[0] = CH_DOT;
						k    = 2'd1;
						if (({2'b00, cnt_q} + (CNT_W+2)'(2)) >= NB) begin
							stop_n = 1'b1;
							go_on  = 1'b0;
						end
					end
				end
				if (go_on) begin
					if (in_byte == CH_SEMI || in_byte == CH_NUL) begin
						stop_n = 1'b1;
					end else if (is_bad(in_byte)) begin
						inv_n  = 1'b1;
						stop_n = 1'b1;
						held_n = 1'b0;
					end else if (in_byte == CH_DOT) begin
						held_n = 1'b1;
					end else begin
						e[k] = in_byte;
						k    = k + 2'd1;
					end
				end
			end
		end
		cnt_w = {2'b00, cnt_q} + {{CNT_W{1'b0}}, k};
		if (cnt_w + (CNT_W+2)'(1) >= NB)
			stop_n = 1'b1;
		// a dot still held at the end of the name goes out
		if (in_last && held_n && !stop_n) begin
			e[k]   = CH_DOT;
			k      = k + 2'd1;
			cnt_w  = cnt_w + (CNT_W+2)'(1);
			held_n = 1'b0;
		end
	end

	always_comb begin
		dots_n = dots_q;
		for (int i = 0; i < 3; i++)
			if (2'(i) < k && e[i] != CH_DOT)
				dots_n = 1'b0;
	end

	always_comb begin
		if (single_dot)
			st = ST_DOTNAME;
		else if (inv_n || cnt_w == '0)
			st = ST_INVALID;
		else if (dots_n && (cnt_w == (CNT_W+2)'(1) || cnt_w == (CNT_W+2)'(2)))
			st = ST_DOTNAME;
		else
			st = ST_OK;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i].out_byte   = e[i];
			res[i].byte_valid = 2'(i) < k;
			res[i].name_done  = 1'b0;
			res[i].status     = ST_OK;
			res[i].run_last   = 1'b0;
		end
		if (in_last) begin
			res_n = (k == 2'd0) ? 2'd1 : k;
			res[res_n - 2'd1].name_done = 1'b1;
			res[res_n - 2'd1].status    = st;
			res[res_n - 2'd1].run_last  = 1'b1;
		end else begin
			res_n = k;
			if (k != 2'd0)
				res[k - 2'd1].run_last = 1'b1;
		end
	end

	assign started_n = 1'b1;
	assign nj_n      = nj;
	assign cnt_n     = cnt_w[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			nj_q      <= 1'b0;
			hi_q      <= 8'h00;
			ph_q      <= 1'b0;
			cnt_q     <= '0;
			stop_q    <= 1'b0;
			held_q    <= 1'b0;
			inv_q     <= 1'b0;
			dots_q    <= 1'b1;
		end else if (go) begin
			if (in_last) begin
				started_q <= 1'b0;
				nj_q      <= 1'b0;
				hi_q      <= 8'h00;
				ph_q      <= 1'b0;
				cnt_q     <= '0;
				stop_q    <= 1'b0;
				held_q    <= 1'b0;
				inv_q     <= 1'b0;
				dots_q    <= 1'b1;
			end else begin
				started_q <= started_n;
				nj_q      <= nj_n;
				hi_q      <= hi_n;
				ph_q      <= ph_n;
				cnt_q     <= cnt_n;
				stop_q    <= stop_n;
				held_q    <= held_n;
				inv_q     <= inv_n;
				dots_q    <= dots_n;
			end
		end
	end

endmodule

/* rtl/iso_dec_obuf.sv */
module iso_dec_obuf import iso_dec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t [2:0] ld_res,
	input  logic [1:0] ld_n,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       out_res
);

	res_t [2:0] r_q;
	logic [1:0] n_q, rd_q;
	logic       take, at_end;

	assign out_valid = n_q != 2'd0;
	assign out_res   = r_q[rd_q];
	assign take      = out_valid && out_ready;
	assign at_end    = rd_q == n_q - 2'd1;
	assign free      = !out_valid || (take && at_end);

	always_ff @(posedge clk) begin
		if (load)
			r_q <= ld_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= 2'd0;
			rd_q <= 2'd0;
		end else if (load) begin
			n_q  <= ld_n;
			rd_q <= 2'd0;
		end else if (take) begin
			if (at_end) begin
				n_q  <= 2'd0;
				rd_q <= 2'd0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

endmodule

/* rtl/iso9660_name_decoder.sv */
// Each accepted input item is registered, then decoded into the result buffer.
// Throughput: one input item per cycle while each item yields at most one result
//   and m_tready is high; an item yielding k results (k up to 3) holds the decode
//   stage until the single result port drains the three-entry result buffer.
// Reset (arst_n low, asynchronous): stages empty, name state cleared, joliet_mode 0.
module iso9660_name_decoder import iso_dec_pkg::*; #(
	parameter int NAME_BUFFER_BYTES = NAME_BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] name_byte
	input  logic        s_tlast,   // last_byte
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
	output logic [1:0]  m_tuser,   // [0] byte_valid, [1] name_done
	output logic        m_tlast,   // run_last
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // joliet_mode
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       joliet_q;

	logic       free, go;
	res_t [2:0] step_res;
	logic [1:0] step_n;
	res_t       cur;

	// Decode step fires when the input stage holds an item and the
	// result buffer is empty or hands over its final entry this cycle.
	assign go       = v_s1 && free;
	assign s_tready = !v_s1 || go;
	assign cfg_ready = 1'b1;

	// Input stage: plain register, refills in the same cycle it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Mode register; the core latches it at the first byte of each name.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joliet_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			joliet_q <= cfg_data;
		end
	end

	iso_dec_core #(
		.NAME_BUFFER_BYTES(NAME_BUFFER_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.joliet_mode (joliet_q),
		.in_byte     (byte_s1),
		.in_last     (last_s1),
		.res         (step_res),
		.res_n       (step_n)
	);

	// Result buffer: up to three results per item, one out per cycle while m_tready is high.
	iso_dec_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go),
		.ld_res    (step_res),
		.ld_n      (step_n),
		.free      (free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (cur)
	);

	assign m_tdata = {6'b000000, cur.status, cur.out_byte};
	assign m_tuser = {cur.name_done, cur.byte_valid};
	assign m_tlast = cur.run_last;

`ifndef NO_ASSERTIONS
	// the end-of-name result is always the final result of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("name_done without run_last");

	// an empty result only exists to carry the end of a name
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[1])
		else $error("empty result without name_done");

	// status is zero except on the end-of-name result, and never code 3
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1] || m_tdata[9:8] == ST_OK) && m_tdata[9:8] != 2'd3)
		else $error("bad status on result");

	// an item in the input stage is not dropped while the buffer is busy
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !free |=> v_s1)
		else $error("input stage lost an item");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import iso_dec_pkg::*;

	localparam int NAME_BYTES = NAME_BUFFER_BYTES_DEF;
	// Watchdog: cycles in a row without any handshake on any channel.
	localparam int WD_LIMIT = 2000;
	// Short random names stop once this many of their items went in.
	localparam int SHORT_ITEMS = 215;
	// Settle time after the last result before a mode write or the end.
	localparam int SETTLE = 6;

	// Characters the decoder rejects besides control codes
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] name_byte
	logic        s_tlast = 1'b0; // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] out_byte, [9:8] status, [15:10] zero
	logic [1:0]  m_tuser;        // [0] byte_valid, [1] name_done
	logic        m_tlast;        // run_last
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;  // joliet_mode

	iso9660_name_decoder #(
		.NAME_BUFFER_BYTES(NAME_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Name decoder model: mirrors the block's running name state.
	// ------------------------------------------------------------------
	logic        jol_reg;      // shadow of the joliet_mode register
	logic [7:0]  nm_high;      // first byte of a pending UCS-2 pair
	logic        nm_phase;     // 1 while a pair is half collected
	int          nm_count;     // bytes emitted so far
	logic        nm_stopped;
	logic        nm_held;      // plain-mode dot waiting for its successor
	logic        nm_invalid;
	logic [7:0]  nm_first;
	logic        nm_multi;
	logic        nm_dots_only;
	logic        nm_started;
	logic        nm_jol;       // mode latched at the first byte of the name

	res_t        step_out[$];   // results of the byte just decoded
	res_t        decoded_q[$];  // decoded bytes still due from the block
	logic [7:0]  name_buf[$];   // raw bytes of the name being sent

	function automatic void clear_name();
		nm_high = '0; nm_phase = 1'b0; nm_count = 0; nm_stopped = 1'b0;
		nm_held = 1'b0; nm_invalid = 1'b0; nm_first = '0; nm_multi = 1'b0;
		nm_dots_only = 1'b1; nm_started = 1'b0; nm_jol = 1'b0;
	endfunction

	function automatic void put_res(logic [7:0] v, logic valid);
		res_t r;
		r = '0;
		r.out_byte = v;
		r.byte_valid = valid;
		step_out.push_back(r);
	endfunction

	function automatic void emit_char(logic [7:0] c);
		put_res(c, 1'b1);
		if (c != CH_DOT)
			nm_dots_only = 1'b0;
		nm_count++;
		// buffer keeps one slot for the terminator
		if (nm_count + 1 >= NAME_BYTES)
			nm_stopped = 1'b1;
	endfunction

	function automatic bit is_bad(int c);
		return c < 32 || c == CH_SLASH || c == CH_BSLASH || c == CH_COLON;
	endfunction

	function automatic void fail_name();
		nm_invalid = 1'b1;
		nm_stopped = 1'b1;
		nm_held = 1'b0;
	endfunction

	function automatic void joliet_unit(logic [15:0] cp);
		if (cp == 16'h0000 || cp == {8'h00, CH_SEMI}) begin
			nm_stopped = 1'b1;
			return;
		end
		if (cp > 16'h007F) begin
			// wide units need three free slots even when two would do
			if (nm_count + 3 < NAME_BYTES) begin
				if (cp < 16'h0800) begin
					emit_char(UTF_LEAD2 | {3'b000, cp[10:6]});
					emit_char(UTF_CONT | {2'b00, cp[5:0]});
				end else begin
					emit_char(UTF_LEAD3 | {4'b0000, cp[15:12]});
					emit_char(UTF_CONT | {2'b00, cp[11:6]});
					emit_char(UTF_CONT | {2'b00, cp[5:0]});
				end
			end
			return;
		end
		if (is_bad(cp)) begin
			fail_name();
			return;
		end
		emit_char(cp[7:0]);
	endfunction

	function automatic void plain_char(logic [7:0] b);
		if (nm_held) begin
			nm_held = 1'b0;
			// dot right before the version separator is dropped
			if (b == CH_SEMI) begin
				nm_stopped = 1'b1;
				return;
			end
			emit_char(CH_DOT);
			if (nm_stopped)
				return;
		end
		if (b == CH_SEMI || b == CH_NUL) begin
			nm_stopped = 1'b1;
			return;
		end
		if (is_bad(b)) begin
			fail_name();
			return;
		end
		if (b == CH_DOT) begin
			nm_held = 1'b1;
			return;
		end
		emit_char(b);
	endfunction

	// Decode one raw byte; the results land in step_out.
	function automatic void decode_step(logic [7:0] b, logic last);
		bit one_dot;
		logic [1:0] st;
		res_t r;
		step_out.delete();
		if (!nm_started) begin
			nm_started = 1'b1;
			nm_first = b;
			nm_jol = jol_reg;
		end else begin
			nm_multi = 1'b1;
		end
		one_dot = last && !nm_multi && nm_first <= 8'h01;

		if (!one_dot && !nm_stopped) begin
			if (nm_jol) begin
				if (!nm_phase) begin
					// a final byte opening a pair is pad
					if (!last) begin
						nm_high = b;
						nm_phase = 1'b1;
					end
				end else begin
					nm_phase = 1'b0;
					joliet_unit({nm_high, b});
				end
			end else begin
				plain_char(b);
			end
		end

		if (last) begin
			if (nm_held && !nm_stopped) begin
				nm_held = 1'b0;
				emit_char(CH_DOT);
			end
			if (one_dot)
				st = ST_DOTNAME;
			else if (nm_invalid || nm_count == 0)
				st = ST_INVALID;
			else if (nm_dots_only && (nm_count == 1 || nm_count == 2))
				st = ST_DOTNAME;
			else
				st = ST_OK;
			if (step_out.size() == 0)
				put_res(8'h00, 1'b0);
			r = step_out.pop_back();
			r.name_done = 1'b1;
			r.status = st;
			step_out.push_back(r);
			clear_name();
		end

		if (step_out.size() > 0) begin
			r = step_out.pop_back();
			r.run_last = 1'b1;
			step_out.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Random byte sources
	// ------------------------------------------------------------------
	function automatic logic [7:0] safe_char();
		logic [7:0] c;
		c = 8'($urandom_range(32, 126));
		while (is_bad(c) || c == CH_SEMI || c == CH_DOT)
			c = 8'($urandom_range(32, 126));
		return c;
	endfunction

	function automatic logic [7:0] pick_bad();
		case ($urandom_range(0, 3))
			0: return CH_SLASH;
			1: return CH_BSLASH;
			2: return CH_COLON;
			default: return 8'($urandom_range(1, 31));
		endcase
	endfunction

	// Plain name: clean ones hold safe printable characters, dots and high bytes only.
	function automatic void build_plain(int len, bit noisy);
		int r;
		logic [7:0] c;
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (!noisy) begin
				if (r < 75) c = safe_char();
				else if (r < 90) c = CH_DOT;
				else c = 8'($urandom_range(8'h80, 8'hFF));
			end else begin
				if (r < 50) c = safe_char();
				else if (r < 65) c = CH_DOT;
				else if (r < 72) c = CH_SEMI;
				else if (r < 77) c = CH_NUL;
				else if (r < 87) c = pick_bad();
				else if (r < 95) c = 8'($urandom_range(8'h80, 8'hFF));
				else c = 8'($urandom_range(0, 255));
			end
			name_buf.push_back(c);
		end
	endfunction

	// One big-endian UCS-2 unit into the name
	function automatic void push_unit(logic [15:0] u);
		name_buf.push_back(u[15:8]);
		name_buf.push_back(u[7:0]);
	endfunction

	// Joliet name: big-endian UCS-2 units, optional odd pad byte.
	function automatic void build_joliet(int units, bit noisy, bit pad);
		int r;
		logic [15:0] u;
		repeat (units) begin
			r = $urandom_range(0, 99);
			if (noisy && r < 30) begin
				case (r % 4)
					0: u = 16'h0000;
					1: u = {8'h00, CH_SEMI};
					2: u = {8'h00, pick_bad()};
					default: u = 16'($urandom_range(0, 16'hFFFF));
				endcase
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) u = {8'h00, safe_char()};
				else if (r < 60) u = {8'h00, CH_DOT};
				else if (r < 80) u = 16'($urandom_range(16'h0080, 16'h07FF));
				else u = 16'($urandom_range(16'h0800, 16'hFFFF));
			end
			push_unit(u);
		end
		if (pad)
			name_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 92) return $urandom_range(1, 3);
		else return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int n_items, n_res, n_fail, n_names, n_cfg, short_items;
	bit calm;  // no input gaps for the current name

	// Drive one item at the falling edge, hold until accepted, then predict.
	task automatic send_item(logic [7:0] b, logic last, bit typed, res_t want);
		int g;
		g = calm ? 0 : gap_len();
		@(negedge clk);
		if (g > 0) begin
			s_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_step(b, last);
		if (typed)
			decoded_q.push_back(want);
		else
			foreach (step_out[k]) decoded_q.push_back(step_out[k]);
		n_items++;
	endtask

	// Bytes may yield nothing, so pad with the settle time after the queue drains.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(logic v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		jol_reg = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Directed rows: mode, byte, last, typed result flag, typed byte/valid/status.
	typedef struct packed {
		logic       jol;
		logic [7:0] b;
		logic       last;
		logic       typed;
		logic [7:0] w_byte;
		logic       w_valid;
		logic [1:0] w_status;
	} dir_row_t;

	dir_row_t dir_rows [0:26] = '{
		// plain mode
		'{1'b0, 8'h41,     1'b1, 1'b1, 8'h41,  1'b1, ST_OK},      // one letter
		'{1'b0, CH_NUL,    1'b1, 1'b1, 8'h00,  1'b0, ST_DOTNAME}, // self entry byte
		'{1'b0, 8'hFF,     1'b1, 1'b1, 8'hFF,  1'b1, ST_OK},      // top byte passes
		'{1'b0, CH_DOT,    1'b1, 1'b1, CH_DOT, 1'b1, ST_DOTNAME}, // "."
		'{1'b0, CH_DOT,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // ".."
		'{1'b0, CH_DOT,    1'b1, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b0, 8'h41,     1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // "A.;" drops dot
		'{1'b0, CH_DOT,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b0, CH_SEMI,   1'b1, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b0, CH_SLASH,  1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // bad, rest ignored
		'{1'b0, 8'h42,     1'b1, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b0, CH_SEMI,   1'b1, 1'b1, 8'h00,  1'b0, ST_INVALID}, // empty output
		'{1'b0, CH_BSLASH, 1'b1, 1'b1, 8'h00,  1'b0, ST_INVALID},
		// Joliet mode
		'{1'b1, CH_NUL,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // U+0041
		'{1'b1, 8'h41,     1'b1, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b1, CH_NUL,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // U+00E9, U+FFFF
		'{1'b1, 8'hE9,     1'b0, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b1, 8'hFF,     1'b0, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b1, 8'hFF,     1'b1, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b1, CH_NUL,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // odd length pad
		'{1'b1, 8'h7A,     1'b0, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b1, 8'h55,     1'b1, 1'b0, 8'h00,  1'b0, ST_OK},
		'{1'b1, 8'h01,     1'b1, 1'b1, 8'h00,  1'b0, ST_DOTNAME}, // parent entry byte
		'{1'b1, CH_NUL,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // colon unit
		'{1'b1, CH_COLON,  1'b1, 1'b1, 8'h00,  1'b0, ST_INVALID},
		'{1'b1, CH_NUL,    1'b0, 1'b0, 8'h00,  1'b0, ST_OK},      // mode flips mid-name
		'{1'b0, 8'h42,     1'b1, 1'b0, 8'h00,  1'b0, ST_OK}
	};

	initial begin
		res_t want;
		bit mid;
		bit long_name;
		int r;

		jol_reg = 1'b0;
		clear_name();
		calm = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		write_mode(1'b0);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].jol != jol_reg) begin
				wait_idle();
				write_mode(dir_rows[i].jol);
			end
			want = '0;
			want.out_byte = dir_rows[i].w_byte;
			want.byte_valid = dir_rows[i].w_valid;
			want.name_done = 1'b1;
			want.status = dir_rows[i].w_status;
			want.run_last = 1'b1;
			send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, want);
			if (dir_rows[i].last)
				n_names++;
		end

		// random names; one long Joliet name fills the output buffer
		while (short_items < SHORT_ITEMS) begin
			long_name = (n_names == 30);
			calm = ($urandom_range(0, 7) == 0);
			if (long_name) begin
				if (!jol_reg) begin
					wait_idle();
					write_mode(1'b1);
				end
			end else if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				write_mode(1'($urandom_range(0, 1)));
			end

			name_buf.delete();
			if (long_name) begin
				// three-byte units up to 252 bytes, a two-byte unit to 254,
				// then a wide unit with no room, a letter that fills the
				// buffer and a bad unit that must not count
				repeat (84)
					push_unit(16'($urandom_range(16'h0800, 16'hFFFF)));
				push_unit(16'($urandom_range(16'h0080, 16'h07FF)));
				push_unit(16'($urandom_range(16'h0800, 16'hFFFF)));
				push_unit(16'h0041);
				name_buf.push_back(8'h00);
				name_buf.push_back(CH_SLASH);
				name_buf.push_back(8'h00);
				name_buf.push_back(8'h42);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					case ($urandom_range(0, 3))
						0: name_buf.push_back(CH_NUL);
						1: name_buf.push_back(8'h01);
						2: name_buf.push_back(CH_DOT);
						default: name_buf.push_back(8'($urandom_range(0, 255)));
					endcase
				end else if (jol_reg) begin
					build_joliet($urandom_range(1, 8), $urandom_range(0, 9) < 3,
						$urandom_range(0, 3) == 0);
				end else begin
					build_plain($urandom_range(2, 12), $urandom_range(0, 9) < 3);
				end
				short_items += name_buf.size();
			end

			mid = (name_buf.size() > 1) && ($urandom_range(0, 19) == 0);
			foreach (name_buf[i]) begin
				// a write inside a name must not change how it decodes
				if (mid && i == 1) begin
					wait_idle();
					write_mode(!jol_reg);
				end
				send_item(name_buf[i], i == name_buf.size() - 1, 1'b0, '0);
			end
			n_names++;
		end

		wait_idle();
		$display("%0d names (%0d input items) decoded, %0d results checked, %0d mode writes",
			n_names, n_items, n_res, n_cfg);
		$display("covered both modes, dot entries, pads, bad bytes and a full %0d-byte buffer",
			NAME_BYTES);
		if (n_fail == 0 && decoded_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure, with stretches of none.
	// ------------------------------------------------------------------
	int m_hold, m_calm;

	always @(negedge clk) begin
		if (m_hold > 0) begin
			m_tready = 1'b0;
			m_hold--;
		end else if (m_calm > 0) begin
			m_tready = 1'b1;
			m_calm--;
		end else begin
			m_tready = 1'b1;
			case ($urandom_range(0, 19))
				0: m_calm = $urandom_range(20, 80);
				1, 2, 3, 4: m_hold = gap_len();
				default: ;
			endcase
		end
	end

	task automatic check_field(string nm, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, nm, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected item, tdata %h tuser %h tlast %b",
					$time, m_tdata, m_tuser, m_tlast);
				n_fail++;
			end else begin
				want = decoded_q.pop_front();
				check_field("out_byte", want.out_byte, m_tdata[7:0]);
				check_field("byte_valid", want.byte_valid, m_tuser[0]);
				check_field("name_done", want.name_done, m_tuser[1]);
				check_field("status", want.status, m_tdata[9:8]);
				check_field("run_last", want.run_last, m_tlast);
				n_res++;
			end
		end
	end

	// Watchdog on cycles with no handshake anywhere
	int quiet;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WD_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, WD_LIMIT, decoded_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
